### rtl/sfir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfir_pkg;

   typedef logic signed [15:0] q15_type;
   typedef logic [9:0]         delay_type;
   typedef logic [6:0]         num_taps_type;
   typedef logic [5:0]         tap_index_type;
   typedef logic               csr_index_type;
   typedef logic [9:0]         csr_data_type;

   // one tap slot as held in the tap memory
   typedef struct packed {
      q15_type   coeff;
      delay_type delay;
   } tap_entry_type;

   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   localparam csr_index_type REG_NUM_TAPS  = 1'b0;
   localparam csr_index_type REG_MAX_DELAY = 1'b1;

   localparam num_taps_type NUM_TAPS_RESET  = 7'd1;
   localparam delay_type    MAX_DELAY_RESET = 10'd1023;

   localparam q15_type Q15_MAX = 16'sh7FFF;
   localparam q15_type Q15_MIN = 16'sh8000;

endpackage

`default_nettype wire

### rtl/sfir_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfir_req_if;
   import sfir_pkg::*;

   logic      valid;
   logic      ready;
   logic      command;
   q15_type   sample;
   logic [5:0] tap_index;
   q15_type   tap_coeff;
   delay_type tap_delay;

   modport source (output valid, command, sample, tap_index, tap_coeff, tap_delay,
                   input ready);
   modport sink   (input valid, command, sample, tap_index, tap_coeff, tap_delay,
                   output ready);
endinterface

interface sfir_rsp_if;
   import sfir_pkg::*;

   logic    valid;
   logic    ready;
   q15_type filtered;
   logic    saturated;

   modport source (output valid, filtered, saturated, input ready);
   modport sink   (input valid, filtered, saturated, output ready);
endinterface

`default_nettype wire

### rtl/sparse_fir_q15.sv
// Sparse FIR filter on Q15 samples.
// Requests arrive on req_chan (valid/ready). A load request (command 1) stores
// one tap, coefficient and delay, and gives no response. A filter request
// (command 0) writes the sample into the circular delay line, then runs one
// multiply-accumulate per active tap through a single shared 16x16 multiplier,
// one tap per cycle, and posts one response on rsp_chan. req_chan.ready stays
// low from acceptance until the response is posted.
// The response sits in an output register, so a new request is accepted while
// it waits; if the receiver still holds off when the next sum is finished, the
// block waits in its done state until the register frees up.
// Registers num_taps and max_delay are written through csr_we/csr_index/
// csr_wdata and should only change while the block is idle.
// After reset the tap memory is cleared by a pass over all MAX_TAPS entries,
// during which no request is accepted. The delay line needs no pass: a fill
// mark makes never-written samples read as zero.
`timescale 1ns / 1ps
`default_nettype none

module sparse_fir_q15 #(
   parameter int MAX_TAPS    = 64,
   parameter int DELAY_DEPTH = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire sfir_pkg::csr_index_type csr_index,
   input  wire sfir_pkg::csr_data_type  csr_wdata,
   sfir_req_if.sink                     req_chan,
   sfir_rsp_if.source                   rsp_chan
);
   import sfir_pkg::*;

   localparam int TAW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TCW  = $clog2(MAX_TAPS + 1);
   localparam int NW   = (TCW > 7) ? TCW : 7;
   localparam int DAW  = $clog2(DELAY_DEPTH);
   localparam int DAW1 = DAW + 1;
   localparam int HW   = $clog2(DELAY_DEPTH + 1);
   localparam int CW   = (DAW > 10) ? DAW : 10;
   localparam int TEW  = $bits(tap_entry_type);

   localparam logic [TAW-1:0] TAP_LAST = TAW'(MAX_TAPS - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;

   logic [2:0]     state_ff, state_in;
   num_taps_type   num_taps_ff;
   delay_type      max_delay_ff;
   logic [TAW-1:0] clr_ff, clr_in;
   logic [DAW-1:0] wpos_ff, wpos_in;
   logic [DAW-1:0] pos_ff, pos_in;
   logic [HW-1:0]  fill_ff, fill_in;
   logic [TAW-1:0] k_ff, k_in;
   logic [TAW-1:0] last_ff, last_in;
   logic           issue_ff, issue_in;
   logic           s1_v_ff, s2_v_ff, s3_v_ff;
   q15_type        coeff_s2_ff;
   logic           live_s2_ff;
   logic signed [31:0] prod_ff;
   logic [31:0]    acc_ff, acc_in;
   logic           rsp_valid_ff, rsp_valid_in;
   q15_type        filtered_ff, filtered_in;
   logic           saturated_ff, saturated_in;

   logic           req_take, take_load, take_filter, tap_ok;
   logic           tap_we;
   logic [TAW-1:0] tap_waddr;
   tap_entry_type  tap_wdata, tap_rdata;
   logic [TEW-1:0] tap_rdata_raw;
   delay_type      load_delay;
   logic [CW-1:0]  maxd_wide, d_wide;
   logic [DAW-1:0] maxd, d_eff, rd_addr, cur_pos;
   logic [DAW1-1:0] wrap_addr;
   logic [NW-1:0]  taps_w;
   logic [15:0]    dly_rdata;
   q15_type        mul_b;
   logic [16:0]    shifted;
   logic           clip;
   logic           out_free;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         num_taps_ff  <= NUM_TAPS_RESET;
         max_delay_ff <= MAX_DELAY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_NUM_TAPS:  num_taps_ff  <= csr_wdata[6:0];
            REG_MAX_DELAY: max_delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // delay in effect is capped by the physical line length
   assign maxd_wide = (CW'(max_delay_ff) > CW'(DELAY_DEPTH - 1)) ?
                      CW'(DELAY_DEPTH - 1) : CW'(max_delay_ff);
   assign maxd = DAW'(maxd_wide);

   always_comb begin
      if (num_taps_ff == '0) begin
         taps_w = NW'(1);
      end else if (NW'(num_taps_ff) > NW'(MAX_TAPS)) begin
         taps_w = NW'(MAX_TAPS);
      end else begin
         taps_w = NW'(num_taps_ff);
      end
   end

   // ---------------- request side ----------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take    = req_chan.valid && req_chan.ready;
   assign take_load   = req_take && (req_chan.command == CMD_LOAD);
   assign take_filter = req_take && (req_chan.command == CMD_FILTER);
   assign tap_ok      = 32'(req_chan.tap_index) < MAX_TAPS;
   assign load_delay  = (req_chan.tap_delay > max_delay_ff) ? max_delay_ff
                                                           : req_chan.tap_delay;

   // stale position restarts at the head of the line
   assign cur_pos = (wpos_ff > maxd) ? '0 : wpos_ff;

   always_comb begin
      tap_we    = 1'b0;
      tap_waddr = clr_ff;
      tap_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         tap_we = 1'b1;
      end else if (take_load && tap_ok) begin
         tap_we          = 1'b1;
         tap_waddr       = TAW'(req_chan.tap_index);
         tap_wdata.coeff = req_chan.tap_coeff;
         tap_wdata.delay = load_delay;
      end
   end

   sfir_ram #(
      .WIDTH (TEW),
      .DEPTH (MAX_TAPS)
   ) u_tap_ram (
      .clock (clock),
      .we    (tap_we),
      .waddr (tap_waddr),
      .wdata (tap_wdata),
      .raddr (k_ff),
      .rdata (tap_rdata_raw)
   );

   assign tap_rdata = tap_rdata_raw;

   // ---------------- tap stage: delay cap and read address ----------------
   assign d_wide = (CW'(tap_rdata.delay) > CW'(maxd)) ? CW'(maxd) : CW'(tap_rdata.delay);
   assign d_eff  = DAW'(d_wide);
   assign wrap_addr = DAW1'(pos_ff) + DAW1'(maxd) + DAW1'(1) - DAW1'(d_eff);
   assign rd_addr   = (pos_ff >= d_eff) ? (pos_ff - d_eff) : DAW'(wrap_addr);

   sfir_ram #(
      .WIDTH (16),
      .DEPTH (DELAY_DEPTH)
   ) u_delay_ram (
      .clock (clock),
      .we    (take_filter),
      .waddr (cur_pos),
      .wdata (req_chan.sample),
      .raddr (rd_addr),
      .rdata (dly_rdata)
   );

   // entries at or above the fill mark were never written and read as zero
   assign mul_b = live_s2_ff ? q15_type'(dly_rdata) : '0;

   always_ff @(posedge clock) begin
      coeff_s2_ff <= tap_rdata.coeff;
      live_s2_ff  <= HW'(rd_addr) < fill_ff;
      prod_ff     <= coeff_s2_ff * mul_b;
   end

   // ---------------- sequencer ----------------
   assign shifted  = acc_ff[31:15];
   assign clip     = shifted[16] != shifted[15];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wpos_in      = wpos_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      issue_in     = issue_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      filtered_in  = filtered_ff;
      saturated_in = saturated_ff;

      if (s3_v_ff) begin
         acc_in = acc_ff + 32'(prod_ff);
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + TAW'(1);
            if (clr_ff == TAP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take_filter) begin
               pos_in   = cur_pos;
               wpos_in  = (cur_pos == maxd) ? '0 : cur_pos + DAW'(1);
               if (HW'(cur_pos) + HW'(1) > fill_ff) begin
                  fill_in = HW'(cur_pos) + HW'(1);
               end
               k_in     = '0;
               last_in  = TAW'(taps_w - NW'(1));
               issue_in = 1'b1;
               acc_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue_ff) begin
               if (k_ff == last_ff) begin
                  issue_in = 1'b0;
               end else begin
                  k_in = k_ff + TAW'(1);
               end
            end else if (!s1_v_ff && !s2_v_ff && !s3_v_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               saturated_in = clip;
               if (clip) begin
                  filtered_in = acc_ff[31] ? Q15_MIN : Q15_MAX;
               end else begin
                  filtered_in = shifted[15:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         issue_ff     <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         issue_ff     <= issue_in;
         s1_v_ff      <= issue_ff;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      k_ff         <= k_in;
      last_ff      <= last_in;
      acc_ff       <= acc_in;
      filtered_ff  <= filtered_in;
      saturated_ff <= saturated_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.filtered  = filtered_ff;
   assign rsp_chan.saturated = saturated_ff;

   // ---------------- checks ----------------
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!issue_ff && !s1_v_ff && !s2_v_ff && !s3_v_ff))
      else $error("mac pipeline busy while accepting requests");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response posted outside done state");

   a_wpos_below_fill: assert property (@(posedge clock) disable iff (reset)
      HW'(wpos_ff) <= fill_ff)
      else $error("write position beyond fill mark");

   a_no_tap_write_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN || state_ff == ST_DONE) |-> !tap_we)
      else $error("tap memory written during a sum");

endmodule

`default_nettype wire

### rtl/sfir_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sfir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
